// ===== rtl/core/tlpt_pkg.sv =====
// Shared types and constants for the three-level page table mapper.
// Holds the request and result structs and the controller/datapath command types.
// No dependencies.
package tlpt_pkg;

  localparam int FRAMES            = 64;
  localparam int ENTRIES_PER_FRAME = 512;
  localparam int FRAME_W           = $clog2(FRAMES);
  localparam int IDX_W             = $clog2(ENTRIES_PER_FRAME);
  localparam int SLOT_W            = FRAME_W + IDX_W;
  localparam int DEPTH             = FRAMES * ENTRIES_PER_FRAME;
  localparam int PN_W              = 44;
  localparam int ENTRY_W           = 54;
  localparam int PA_W              = 56;
  localparam int VA_W              = 39;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MAPPED    = 2'd1;
  localparam logic [1:0] ST_NOFRAME   = 2'd2;
  localparam logic [1:0] ST_NOTMAPPED = 2'd3;

  localparam logic REQ_MAP    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [VA_W-1:0] virt_addr;
    logic [PA_W-1:0] phys_addr;
    logic [2:0]      perm;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [PA_W-1:0]    out_phys_addr;
  } res_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_LOAD,
    DP_READ,
    DP_FOLLOW,
    DP_ALLOC,
    DP_RESULT,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic ent_valid;
    logic link_ok;
    logic have_frame;
    logic is_lookup;
    logic at_leaf;
    logic clr_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/tlpt_dpath.sv =====
// Datapath of the page table mapper: entry store, frame allocator, walk registers.
// Acts on commands from tlpt_ctrl and reports status back. Uses tlpt_pkg.
module tlpt_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  tlpt_pkg::dp_cmd_t          cmd,
  output tlpt_pkg::dp_stat_t         stat,
  input  tlpt_pkg::req_t             in_data,
  input  logic                       cfg_we,
  input  logic [tlpt_pkg::PN_W-1:0]  cfg_data,
  output tlpt_pkg::res_t             out_data
);
  import tlpt_pkg::*;

  typedef struct packed {
    logic               epoch;
    logic [ENTRY_W-1:0] data;
  } mem_word_t;

  mem_word_t          mem [DEPTH];
  mem_word_t          rd_q;
  req_t               req;
  res_t               res;
  logic [PN_W-1:0]    base;
  logic [FRAME_W-1:0] frames_left;
  logic [FRAMES-1:0]  alloc;
  logic [FRAME_W-1:0] frame;
  logic [1:0]         level;
  logic [SLOT_W-1:0]  clr_cnt;

  logic [IDX_W-1:0]   idx;
  logic [SLOT_W-1:0]  slot;
  logic [ENTRY_W-1:0] ent;
  logic [PN_W:0]      diff;
  logic [FRAME_W-1:0] new_frame;
  logic [PN_W-1:0]    link_pn;
  logic [ENTRY_W-1:0] link_ent;
  logic [ENTRY_W-1:0] leaf_ent;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  mem_word_t          mem_wdata;

  always_comb begin
    case (level)
      2'd2:    idx = req.virt_addr[38:30];
      2'd1:    idx = req.virt_addr[29:21];
      default: idx = req.virt_addr[20:12];
    endcase
  end

  assign slot      = {frame, idx};
  // An entry written before its frame was handed out reads as zero.
  assign ent       = (rd_q.epoch == alloc[frame]) ? rd_q.data : '0;
  assign diff      = {1'b0, ent[ENTRY_W-1:10]} - {1'b0, base};
  assign new_frame = frames_left - 1'b1;
  assign link_pn   = base + PN_W'(new_frame);
  assign link_ent  = {link_pn, 9'd0, 1'b1};
  assign leaf_ent  = {req.phys_addr[PA_W-1:12], 6'd0, req.perm, 1'b1};

  assign stat.ent_valid  = ent[0];
  assign stat.link_ok    = !diff[PN_W] && (diff[PN_W-1:0] < PN_W'(FRAMES));
  assign stat.have_frame = (frames_left != '0);
  assign stat.is_lookup  = (req.req_type == REQ_LOOKUP);
  assign stat.at_leaf    = (level == 2'd0);
  assign stat.clr_last   = (clr_cnt == SLOT_W'(DEPTH - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '{epoch: alloc[frame], data: leaf_ent};
    case (cmd.op)
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      DP_ALLOC: begin
        mem_we    = 1'b1;
        // The slot may sit in the frame being handed out; keep it visible then.
        mem_wdata = '{epoch: (new_frame == frame) ? 1'b1 : alloc[frame], data: link_ent};
      end
      DP_RESULT: begin
        mem_we = (cmd.status == ST_OK) && !stat.is_lookup;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.op == DP_READ) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base        <= '0;
      frames_left <= FRAME_W'(FRAMES - 1);
      alloc       <= '0;
      clr_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      if (cmd.op == DP_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.op == DP_ALLOC) begin
        frames_left      <= new_frame;
        alloc[new_frame] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        req   <= in_data;
        frame <= FRAME_W'(FRAMES - 1);
        level <= 2'd2;
      end
      DP_FOLLOW: begin
        frame <= diff[FRAME_W-1:0];
        level <= level - 1'b1;
      end
      DP_ALLOC: begin
        frame <= new_frame;
        level <= level - 1'b1;
      end
      DP_RESULT: begin
        res.status <= cmd.status;
        if (cmd.status == ST_MAPPED) begin
          res.leaf_entry    <= ent;
          res.out_phys_addr <= '0;
        end else if (cmd.status == ST_OK && stat.is_lookup) begin
          res.leaf_entry    <= ent;
          res.out_phys_addr <= {ent[ENTRY_W-1:10], 12'd0};
        end else if (cmd.status == ST_OK) begin
          res.leaf_entry    <= leaf_ent;
          res.out_phys_addr <= '0;
        end else begin
          res.leaf_entry    <= '0;
          res.out_phys_addr <= '0;
        end
      end
      DP_EMIT: out_data <= res;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tlpt_ctrl.sv =====
// Controller of the page table mapper: sequences the clearing pass and each walk.
// Drives tlpt_dpath by command, owns both handshakes. Uses tlpt_pkg.
module tlpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpt_pkg::dp_cmd_t   cmd,
  input  tlpt_pkg::dp_stat_t  stat
);
  import tlpt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_IDLE;
    cmd.status = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.op     = DP_READ;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_DONE;
        cmd.op     = DP_RESULT;
        if (!stat.at_leaf) begin
          if (stat.ent_valid) begin
            if (stat.link_ok) begin
              cmd.op     = DP_FOLLOW;
              state_next = S_READ;
            end else begin
              cmd.status = ST_NOTMAPPED;
            end
          end else if (stat.is_lookup) begin
            cmd.status = ST_NOTMAPPED;
          end else if (!stat.have_frame) begin
            cmd.status = ST_NOFRAME;
          end else begin
            cmd.op     = DP_ALLOC;
            state_next = S_READ;
          end
        end else if (stat.is_lookup) begin
          cmd.status = stat.ent_valid ? ST_OK : ST_NOTMAPPED;
        end else begin
          cmd.status = stat.ent_valid ? ST_MAPPED : ST_OK;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.op     = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/three_level_page_table_mapper_core.sv =====
// Top level of the three-level page table mapper.
// Joins tlpt_ctrl and tlpt_dpath. Uses tlpt_pkg.
//
// Keeps a three-level radix page table (512 entries per level) in an on-chip
// store of FRAMES frames, root in the last frame, and serves map and lookup
// requests one at a time. After reset the block runs a clearing pass over the
// whole store and stalls requests until it ends; the base-page register can be
// written at any time it is idle. A full walk holds the block through the
// accept step, three dependent entry reads, each a read step and a check step
// on the single store port, and the result handoff. A walk that ends early at a
// missing or broken node skips the read and check steps of each level it does
// not reach. The finished result waits in an output register, so the next
// request is taken while it is still stalled; that next request then holds in
// its handoff state until the register frees. Frames are handed out from the
// top down and never freed; a per-frame flag marks a frame as handed out, and
// entries written before that read as zero.
module three_level_page_table_mapper_core (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tlpt_pkg::req_t             in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output tlpt_pkg::res_t             out_data,
  // base page register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tlpt_pkg::PN_W-1:0]  cfg_data
);
  import tlpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Always take register writes; they must arrive only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  tlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  tlpt_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

// ===== verif/tb_three_level_page_table_mapper_core.sv =====
// Self-checking testbench for three_level_page_table_mapper_core: map and lookup
// requests against a cycle-free page-table predictor, with random idling on both sides.
// Depends on tlpt_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_three_level_page_table_mapper_core;
  import tlpt_pkg::*;

  localparam int RESULT_LATENCY = 8;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int MAX_REPORTS    = 10;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  req_t              in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  res_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [PN_W-1:0]   cfg_data  = '0;

  // Predictor state: page-table store, frame allocator and base page register
  logic [ENTRY_W-1:0] pt_mem [DEPTH];
  int                 frames_avail;
  logic [PN_W-1:0]    base_pn;

  res_t               pending[$];      // expected results, oldest first
  int                 mismatches   = 0;
  int                 stray_results = 0;
  int                 requests_sent = 0;
  int                 base_writes  = 0;
  int                 status_seen [4];
  int                 cycle_count  = 0;

  // Receiver idling
  bit                 calm_mode    = 1'b0;
  int                 stall_hold   = 0;
  int                 stall_run    = 0;

  // Address pools that keep random traffic on a few table paths
  logic [IDX_W-1:0]   top_pool  [4];
  logic [IDX_W-1:0]   mid_pool  [4];
  logic [IDX_W-1:0]   leaf_pool [8];

  three_level_page_table_mapper_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Most gaps short, some medium, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode) return 0;
    if (r < 65) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VA_W-1:0] build_va(logic [IDX_W-1:0] top, logic [IDX_W-1:0] mid,
                                              logic [IDX_W-1:0] leaf);
    return {top, mid, leaf, 12'($urandom)};
  endfunction

  function automatic req_t mk_req(logic kind, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                  logic [2:0] perm);
    req_t r;
    r.req_type  = kind;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.perm      = perm;
    return r;
  endfunction

  // Walk the predicted table for one request and update it as the block would
  function automatic res_t walk_table(req_t r);
    res_t               res;
    logic [FRAME_W-1:0] frame;
    logic [IDX_W-1:0]   idx;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] ent;
    logic [63:0]        off;
    logic [1:0]         st;
    int                 lvl;
    int                 j;
    res   = '0;
    frame = FRAME_W'(FRAMES - 1);
    st    = ST_OK;
    lvl   = 2;
    while (lvl > 0 && st == ST_OK) begin
      idx  = r.virt_addr[12 + 9 * lvl +: IDX_W];
      slot = {frame, idx};
      ent  = pt_mem[slot];
      if (ent[0]) begin
        // decode the link; a page number outside the frame store is a broken link
        off = 64'(ent[ENTRY_W-1:10]) - 64'(base_pn);
        if (off >= 64'(FRAMES)) st = ST_NOTMAPPED;
        else frame = off[FRAME_W-1:0];
      end else if (r.req_type == REQ_LOOKUP) begin
        st = ST_NOTMAPPED;
      end else if (frames_avail == 0) begin
        st = ST_NOFRAME;
      end else begin
        frames_avail--;
        frame = FRAME_W'(frames_avail);
        for (j = 0; j < ENTRIES_PER_FRAME; j++) pt_mem[{frame, IDX_W'(j)}] = '0;
        pt_mem[slot] = {PN_W'(base_pn + PN_W'(frame)), 9'b0, 1'b1};
      end
      lvl--;
    end
    if (st == ST_OK) begin
      slot = {frame, r.virt_addr[20:12]};
      ent  = pt_mem[slot];
      if (r.req_type == REQ_LOOKUP) begin
        if (ent[0]) begin
          res.leaf_entry    = ent;
          res.out_phys_addr = {ent[ENTRY_W-1:10], 12'b0};
        end else begin
          st = ST_NOTMAPPED;
        end
      end else if (ent[0]) begin
        st             = ST_MAPPED;
        res.leaf_entry = ent;
      end else begin
        res.leaf_entry = {r.phys_addr[PA_W-1:12], 6'b0, r.perm, 1'b1};
        pt_mem[slot]   = res.leaf_entry;
      end
    end
    res.status = st;
    return res;
  endfunction

  // Present one request, hold it until accepted, then idle for a random gap
  task automatic send_req(input req_t r);
    int gap;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending.push_back(walk_table(r));
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop the request valid and hold until every expected result is back
  task automatic settle_pipeline();
    if (in_valid) in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [PN_W-1:0] value);
    settle_pipeline();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_pn = value;
    base_writes++;
  endtask

  // Random traffic: mostly pooled paths with random content, some noise lookups
  task automatic run_mixed_traffic(input int n);
    req_t             r;
    int               i;
    int               calm_left;
    int               pause_at;
    logic [IDX_W-1:0] t;
    logic [IDX_W-1:0] m;
    logic [IDX_W-1:0] l;
    calm_left = 0;
    pause_at  = $urandom_range(n / 4, 3 * n / 4);
    for (i = 0; i < n; i++) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
      calm_mode = (calm_left > 0);
      if (i == pause_at) settle_pipeline();
      r.phys_addr = PA_W'({$urandom, $urandom});
      r.perm      = 3'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        t = top_pool[$urandom_range(0, 3)];
        m = mid_pool[$urandom_range(0, 3)];
        l = $urandom_range(0, 1) ? leaf_pool[$urandom_range(0, 7)] : IDX_W'($urandom);
        r.virt_addr = build_va(t, m, l);
        r.req_type  = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_MAP;
      end else begin
        // noise: fresh paths, mostly lookups so frames are not burned
        r.virt_addr = VA_W'({$urandom, $urandom});
        r.req_type  = ($urandom_range(0, 9) == 0) ? REQ_MAP : REQ_LOOKUP;
      end
      send_req(r);
    end
    calm_mode = 1'b0;
  endtask

  task automatic test_directed_walks();
    logic [PA_W-1:0] ones;
    ones = '1;
    send_req(mk_req(REQ_LOOKUP, '0, '0, 3'd0));                  // missing node
    send_req(mk_req(REQ_MAP, '0, ones, 3'd7));                   // low pa bits ignored
    send_req(mk_req(REQ_LOOKUP, '0, '0, 3'd0));
    send_req(mk_req(REQ_MAP, '0, '0, 3'd0));                     // leaf already valid
    send_req(mk_req(REQ_LOOKUP, VA_W'(12'hFFF), ones, 3'd7));    // page offset ignored
    send_req(mk_req(REQ_MAP, '1, '0, 3'd0));
    send_req(mk_req(REQ_LOOKUP, '1, ones, 3'd0));
    send_req(mk_req(REQ_MAP, build_va(9'd0, 9'd0, 9'd1), {28{2'b01}}, 3'd1));
    send_req(mk_req(REQ_MAP, build_va(9'd0, 9'd0, 9'd2), {28{2'b10}}, 3'd2));
    send_req(mk_req(REQ_MAP, build_va(9'd0, 9'd0, 9'd3), {{44{1'b1}}, 12'b0}, 3'd4));
    send_req(mk_req(REQ_LOOKUP, build_va(9'd0, 9'd0, 9'd511), '0, 3'd0));  // invalid leaf
    send_req(mk_req(REQ_LOOKUP, build_va(9'd0, 9'd511, 9'd0), '0, 3'd0));  // missing mid
    send_req(mk_req(REQ_MAP, build_va(9'd0, 9'd511, 9'd0), PA_W'({$urandom, $urandom}),
                    3'd5));
    send_req(mk_req(REQ_LOOKUP, build_va(9'd511, 9'd0, 9'd0), '0, 3'd0));
    send_req(mk_req(REQ_LOOKUP, build_va(9'd0, 9'd0, 9'd1), '0, 3'd0));
    send_req(mk_req(REQ_LOOKUP, build_va(9'd0, 9'd0, 9'd2), '0, 3'd0));
    send_req(mk_req(REQ_LOOKUP, build_va(9'd0, 9'd0, 9'd3), '0, 3'd0));
    send_req(mk_req(REQ_LOOKUP, build_va(9'd0, 9'd511, 9'd0), '0, 3'd0));
    send_req(mk_req(REQ_MAP, '1, ones, 3'd7));
  endtask

  // Use up the frame store; steer the count odd so the last walk fails half-way
  task automatic test_frame_exhaustion();
    logic [ENTRY_W-1:0] top_ent;
    int                 m;
    int                 t;
    t       = 0;
    top_ent = pt_mem[{FRAME_W'(FRAMES - 1), 9'd0}];
    if (frames_avail > 0 && frames_avail % 2 == 0 && top_ent[0] &&
        top_ent[ENTRY_W-1:10] < FRAMES) begin
      for (m = 0; m < ENTRIES_PER_FRAME &&
           pt_mem[{top_ent[10 +: FRAME_W], IDX_W'(m)}][0]; m++);
      if (m < ENTRIES_PER_FRAME)
        send_req(mk_req(REQ_MAP, build_va(9'd0, IDX_W'(m), IDX_W'($urandom)),
                        PA_W'({$urandom, $urandom}), 3'($urandom)));
    end
    while (frames_avail > 0) begin
      for (t = 0; t < ENTRIES_PER_FRAME && pt_mem[{FRAME_W'(FRAMES - 1), IDX_W'(t)}][0];
           t++);
      send_req(mk_req(REQ_MAP, build_va(IDX_W'(t), IDX_W'($urandom), IDX_W'($urandom)),
                      PA_W'({$urandom, $urandom}), 3'($urandom)));
    end
    // the last top node stays linked even when its walk ran dry
    send_req(mk_req(REQ_LOOKUP, build_va(IDX_W'(t), 9'd0, 9'd0), '0, 3'd0));
    send_req(mk_req(REQ_MAP, build_va(9'd300, 9'd7, 9'd7), '1, 3'd7));
    send_req(mk_req(REQ_MAP, build_va(9'd0, 9'd300, 9'd7), '1, 3'd7));
  endtask

  // Move the base page so existing links break or land on other frames
  task automatic test_base_page_sweep();
    logic [PN_W-1:0] settings [3];
    int              k;
    int              lens [3];
    settings[0] = '1;
    settings[1] = PN_W'({$urandom, $urandom}) | PN_W'(1) << 20;
    settings[2] = PN_W'(1);
    lens        = '{120, 100, 150};
    for (k = 0; k < 3; k++) begin
      write_base(settings[k]);
      send_req(mk_req(REQ_LOOKUP, '0, '0, 3'd0));
      send_req(mk_req(REQ_MAP, '0, PA_W'({$urandom, $urandom}), 3'($urandom)));
      run_mixed_traffic(lens[k]);
    end
  endtask

  task automatic test_restored_base();
    write_base('0);
    send_req(mk_req(REQ_LOOKUP, '0, '0, 3'd0));
    run_mixed_traffic(330);
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        status_seen[out_data.status]++;
        if (pending.size() == 0) begin
          stray_results++;
          if (mismatches + stray_results <= MAX_REPORTS)
            $display("unexpected result: status %0d leaf %h pa %h", out_data.status,
                     out_data.leaf_entry, out_data.out_phys_addr);
        end else begin
          want = pending.pop_front();
          if (out_data.status != want.status || out_data.leaf_entry != want.leaf_entry ||
              out_data.out_phys_addr != want.out_phys_addr) begin
            mismatches++;
            if (mismatches + stray_results <= MAX_REPORTS)
              $display("mismatch: status exp %0d got %0d, leaf exp %h got %h, pa exp %h got %h",
                       want.status, out_data.status, want.leaf_entry, out_data.leaf_entry,
                       want.out_phys_addr, out_data.out_phys_addr);
          end
        end
      end
      if (calm_mode) begin
        out_stall <= 1'b0;
      end else if (stall_hold > 0) begin
        out_stall <= 1'b1;
        stall_hold--;
      end else if (stall_run > 0) begin
        out_stall <= 1'b0;
        stall_run--;
      end else begin
        out_stall  <= 1'b0;
        stall_run  = $urandom_range(0, 15);
        stall_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) pt_mem[i] = '0;
    for (i = 0; i < 4; i++) status_seen[i] = 0;
    frames_avail = FRAMES - 1;
    base_pn      = '0;
    top_pool     = '{9'd0, 9'd511, IDX_W'($urandom), IDX_W'($urandom)};
    mid_pool     = '{9'd0, 9'd511, IDX_W'($urandom), IDX_W'($urandom)};
    leaf_pool[0] = 9'd0;
    leaf_pool[1] = 9'd511;
    for (i = 2; i < 8; i++) leaf_pool[i] = IDX_W'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_base('0);
    test_directed_walks();
    run_mixed_traffic(350);
    test_frame_exhaustion();
    test_base_page_sweep();
    test_restored_base();

    settle_pipeline();
    repeat (4 * RESULT_LATENCY) @(posedge clk);

    $display("Covered %0d map/lookup requests across %0d base page writes, frames left %0d",
             requests_sent, base_writes, frames_avail);
    $display("Results seen: ok %0d, already mapped %0d, out of frames %0d, not mapped %0d",
             status_seen[ST_OK], status_seen[ST_MAPPED], status_seen[ST_NOFRAME],
             status_seen[ST_NOTMAPPED]);
    if (mismatches == 0 && stray_results == 0 && pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
